// ===== hdl/pmt_pkg.sv =====
// Package for the page map translator: item types, mode, status, flag and
// register codes, and default sizes. Used by every module of the block.
package pmt_pkg;

   localparam int VIRTUAL_PAGES_DEF      = 16384;
   localparam int LOG_WORDS_PER_PAGE_DEF = 8;
   localparam int REAL_PAGE_BITS_DEF     = 16;

   localparam int MODE_W   = 3;
   localparam int VADDR_W  = 25;
   localparam int PAGE_W   = 17;
   localparam int FLAGS_W  = 3;
   localparam int NRP_W    = 16;
   localparam int STATUS_W = 2;
   localparam int RADDR_W  = 24;
   localparam int VPL_W    = 18;
   localparam int RPL_W    = 17;
   localparam int CSR_W    = 18;

   localparam logic [MODE_W-1:0] MODE_FETCH     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STORE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_MAP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WRITE_MAP = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PAGE_FAULT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PROT_FAULT   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

   localparam logic [FLAGS_W-1:0] FLAG_REF     = 3'd1;
   localparam logic [FLAGS_W-1:0] FLAG_DIRTY   = 3'd2;
   localparam logic [FLAGS_W-1:0] FLAG_PROT    = 3'd4;
   localparam logic [FLAGS_W-1:0] FLAGS_VACANT = 3'd6;

   localparam logic CSR_VIRTUAL_PAGE_LIMIT = 1'b0;
   localparam logic CSR_REAL_PAGE_LIMIT    = 1'b1;

   localparam logic [VPL_W-1:0] VPL_RESET = 18'd16384;
   localparam logic [RPL_W-1:0] RPL_RESET = 17'd4096;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VADDR_W-1:0] virtual_address;
      logic [PAGE_W-1:0]  page_number;
      logic [FLAGS_W-1:0] new_flags;
      logic [NRP_W-1:0]   new_real_page;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RADDR_W-1:0]  real_address;
      logic [FLAGS_W-1:0]  entry_flags;
      logic [NRP_W-1:0]    entry_real_page;
      logic                is_vacant;
   } rsp_type;

endpackage

// ===== hdl/pmt_map_mem.sv =====
// Page map storage: one-read one-write synchronous memory with a registered
// read port, plus the sweep that marks every entry vacant after reset.
// Depends on pmt_pkg.
module pmt_map_mem #(
   parameter int VIRTUAL_PAGES  = pmt_pkg::VIRTUAL_PAGES_DEF,
   parameter int REAL_PAGE_BITS = pmt_pkg::REAL_PAGE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         rd_en,
   input  logic [$clog2(VIRTUAL_PAGES)-1:0]             rd_addr,
   output logic [pmt_pkg::FLAGS_W+REAL_PAGE_BITS-1:0]   rd_data,
   input  logic                                         wr_en,
   input  logic [$clog2(VIRTUAL_PAGES)-1:0]             wr_addr,
   input  logic [pmt_pkg::FLAGS_W+REAL_PAGE_BITS-1:0]   wr_data,
   output logic                                         clear_busy
);
   import pmt_pkg::*;

   localparam int IDX_W   = $clog2(VIRTUAL_PAGES);
   localparam int ENTRY_W = FLAGS_W + REAL_PAGE_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VIRTUAL_PAGES - 1);

   logic [ENTRY_W-1:0] mem [VIRTUAL_PAGES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assign mem_we    = clr_busy_ff || wr_en;
   assign mem_waddr = clr_busy_ff ? clr_idx_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? {FLAGS_VACANT, {REAL_PAGE_BITS{1'b0}}} : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== hdl/pmt_access.sv =====
// Access stage: takes one item, reads its map entry, checks and marks it,
// writes the entry back and holds the result item. Holds the limit registers.
// Depends on pmt_pkg; drives the ports of pmt_map_mem.
module pmt_access #(
   parameter int VIRTUAL_PAGES      = pmt_pkg::VIRTUAL_PAGES_DEF,
   parameter int LOG_WORDS_PER_PAGE = pmt_pkg::LOG_WORDS_PER_PAGE_DEF,
   parameter int REAL_PAGE_BITS     = pmt_pkg::REAL_PAGE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  pmt_pkg::req_type                             req_data,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output pmt_pkg::rsp_type                             rsp_data,
   input  logic                                         csr_we,
   input  logic                                         csr_index,
   input  logic [pmt_pkg::CSR_W-1:0]                    csr_data,
   input  logic                                         clear_busy,
   output logic                                         rd_en,
   output logic [$clog2(VIRTUAL_PAGES)-1:0]             rd_addr,
   input  logic [pmt_pkg::FLAGS_W+REAL_PAGE_BITS-1:0]   rd_data,
   output logic                                         wr_en,
   output logic [$clog2(VIRTUAL_PAGES)-1:0]             wr_addr,
   output logic [pmt_pkg::FLAGS_W+REAL_PAGE_BITS-1:0]   wr_data
);
   import pmt_pkg::*;

   localparam int IDX_W   = $clog2(VIRTUAL_PAGES);
   localparam int ENTRY_W = FLAGS_W + REAL_PAGE_BITS;
   localparam int VP_W    = VADDR_W - LOG_WORDS_PER_PAGE;
   localparam int CMP_W   = (VP_W > VPL_W) ? VP_W : VPL_W;
   localparam int RA_W    = REAL_PAGE_BITS + LOG_WORDS_PER_PAGE;
   localparam logic [CMP_W-1:0] PAGES_CMP = CMP_W'(VIRTUAL_PAGES);

   logic [VPL_W-1:0] vpl_ff;
   logic [RPL_W-1:0] rpl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vpl_ff <= VPL_RESET;
         rpl_ff <= RPL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VIRTUAL_PAGE_LIMIT: vpl_ff <= csr_data;
            CSR_REAL_PAGE_LIMIT:    rpl_ff <= csr_data[RPL_W-1:0];
            default:                vpl_ff <= vpl_ff;
         endcase
      end
   end

   logic                          stg_valid_ff, stg_valid_in;
   logic [MODE_W-1:0]             stg_mode_ff;
   logic [CMP_W-1:0]              stg_vp_ff;
   logic [LOG_WORDS_PER_PAGE-1:0] stg_off_ff;
   logic [FLAGS_W-1:0]            stg_nf_ff;
   logic [NRP_W-1:0]              stg_nrp_ff;
   logic                          fwd_hit_ff;
   logic [ENTRY_W-1:0]            fwd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic                          req_fire, stg_fire;
   logic [CMP_W-1:0]              vp_in;
   logic [ENTRY_W-1:0]            entry;
   logic [FLAGS_W-1:0]            f;
   logic [REAL_PAGE_BITS-1:0]     rp;
   logic                          vac, in_range, nrp_ok, wr_need;
   logic [STATUS_W-1:0]           status;
   logic [FLAGS_W-1:0]            wr_flags;
   logic [REAL_PAGE_BITS-1:0]     wr_real;
   logic [RA_W-1:0]               ra_full;

   assign stg_fire  = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy && (!stg_valid_ff || stg_fire);
   assign req_fire  = req_valid && req_ready;

   assign vp_in   = (req_data.mode <= MODE_TRANSLATE)
                    ? CMP_W'(req_data.virtual_address >> LOG_WORDS_PER_PAGE)
                    : CMP_W'(req_data.page_number);
   assign rd_en   = req_fire;
   assign rd_addr = vp_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_mode_ff <= req_data.mode;
         stg_vp_ff   <= vp_in;
         stg_off_ff  <= req_data.virtual_address[LOG_WORDS_PER_PAGE-1:0];
         stg_nf_ff   <= req_data.new_flags;
         stg_nrp_ff  <= req_data.new_real_page;
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign entry    = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign f        = entry[ENTRY_W-1 -: FLAGS_W];
   assign vac      = (f == FLAGS_VACANT);
   assign rp       = vac ? '0 : entry[REAL_PAGE_BITS-1:0];
   assign in_range = (stg_mode_ff <= MODE_WRITE_MAP) && (stg_vp_ff < CMP_W'(vpl_ff))
                     && (stg_vp_ff < PAGES_CMP);
   assign nrp_ok   = (RPL_W'(stg_nrp_ff) < rpl_ff)
                     && ((REAL_PAGE_BITS >= NRP_W) || ((stg_nrp_ff >> REAL_PAGE_BITS) == '0));
   assign ra_full  = {rp, stg_off_ff};

   always_comb begin
      status   = STATUS_OK;
      wr_need  = 1'b0;
      wr_flags = f;
      wr_real  = entry[REAL_PAGE_BITS-1:0];
      unique case (stg_mode_ff)
         MODE_FETCH: begin
            if (vac) begin
               status = STATUS_PAGE_FAULT;
            end else begin
               wr_need  = 1'b1;
               wr_flags = f | FLAG_REF;
            end
         end
         MODE_STORE: begin
            priority if (vac) begin
               status = STATUS_PAGE_FAULT;
            end else if ((f & FLAG_PROT) != '0) begin
               status = STATUS_PROT_FAULT;
            end else begin
               wr_need  = 1'b1;
               wr_flags = f | FLAG_REF | FLAG_DIRTY;
            end
         end
         MODE_TRANSLATE: begin
            if (vac) begin
               status = STATUS_PAGE_FAULT;
            end
         end
         MODE_READ_MAP: begin
            status = STATUS_OK;
         end
         MODE_WRITE_MAP: begin
            if (!nrp_ok) begin
               status = STATUS_OUT_OF_RANGE;
            end else begin
               wr_need  = 1'b1;
               wr_flags = stg_nf_ff;
               wr_real  = (stg_nf_ff == FLAGS_VACANT) ? '0
                          : REAL_PAGE_BITS'(stg_nrp_ff);
            end
         end
         default: begin
            status = STATUS_OUT_OF_RANGE;
         end
      endcase

      rsp_data_in = '0;
      rsp_data_in.status = STATUS_OUT_OF_RANGE;
      if (in_range && (status != STATUS_OUT_OF_RANGE)) begin
         rsp_data_in.status          = status;
         rsp_data_in.entry_flags     = f;
         rsp_data_in.entry_real_page = NRP_W'(rp);
         rsp_data_in.is_vacant       = vac;
         if ((stg_mode_ff <= MODE_TRANSLATE) && (status == STATUS_OK)) begin
            rsp_data_in.real_address = RADDR_W'(ra_full);
         end
      end
   end

   assign wr_en   = stg_fire && in_range && wr_need;
   assign wr_addr = stg_vp_ff[IDX_W-1:0];
   assign wr_data = {wr_flags, wr_real};

   always_comb begin
      stg_valid_in = stg_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (stg_fire) begin
         stg_valid_in = 1'b0;
      end
      if (req_fire) begin
         stg_valid_in = 1'b1;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stg_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/page_map_translate_and_mark.sv =====
// Page map translator with referenced and dirty marking. An accepted request
// item passes the stage register, then waits in the result register. One
// item per cycle while the result is not stalled and no clear runs; a map
// read at accept takes the write-back of the item ahead through a forwarding
// register. Reset: limits return to defaults, then a sweep marks every entry
// vacant with req_ready low. Depends on pmt_pkg, pmt_map_mem and pmt_access.
module page_map_translate_and_mark #(
   parameter int VIRTUAL_PAGES      = pmt_pkg::VIRTUAL_PAGES_DEF,
   parameter int LOG_WORDS_PER_PAGE = pmt_pkg::LOG_WORDS_PER_PAGE_DEF,
   parameter int REAL_PAGE_BITS     = pmt_pkg::REAL_PAGE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pmt_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pmt_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [pmt_pkg::CSR_W-1:0]  csr_data
);
   import pmt_pkg::*;

   localparam int IDX_W   = $clog2(VIRTUAL_PAGES);
   localparam int ENTRY_W = FLAGS_W + REAL_PAGE_BITS;

   logic               clear_busy;
   logic               rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;

   pmt_map_mem #(
      .VIRTUAL_PAGES  (VIRTUAL_PAGES),
      .REAL_PAGE_BITS (REAL_PAGE_BITS)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   pmt_access #(
      .VIRTUAL_PAGES      (VIRTUAL_PAGES),
      .LOG_WORDS_PER_PAGE (LOG_WORDS_PER_PAGE),
      .REAL_PAGE_BITS     (REAL_PAGE_BITS)
   ) u_access (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .clear_busy (clear_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

endmodule

// ===== hdl/pmt_checker.sv =====
// Port-level checks for page_map_translate_and_mark and the bind that
// attaches them. Depends on pmt_pkg.
module pmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pmt_pkg::rsp_type  rsp_data
);
   import pmt_pkg::*;

   // hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // block requests once reset is seen, as the map clear starts
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during map clear");

   a_vacant_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_vacant |->
         rsp_data.entry_flags == FLAGS_VACANT && rsp_data.entry_real_page == '0
         && rsp_data.status != STATUS_PROT_FAULT)
      else $error("vacant entry reported inconsistently");

   a_fault_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.real_address == '0)
      else $error("real address given on a failed item");

endmodule

bind page_map_translate_and_mark pmt_checker u_pmt_checker (.*);

// ===== tb/page_map_translate_and_mark_tb.sv =====
// Self-checking bench for page_map_translate_and_mark: a shadow page map predicts
// every result item and a scoreboard compares it field by field. Needs pmt_pkg.
`timescale 1ns / 100ps

module page_map_translate_and_mark_tb;
   import pmt_pkg::*;

   localparam int LW          = LOG_WORDS_PER_PAGE_DEF;
   localparam int PAGE_MAX    = (1 << PAGE_W) - 1;
   localparam int NRP_MAX     = (1 << NRP_W) - 1;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 140;

   class page_map_shadow;
      logic [FLAGS_W-1:0] flag_mem [VIRTUAL_PAGES_DEF];
      logic [NRP_W-1:0]   page_mem [VIRTUAL_PAGES_DEF];
      int                 vpl;
      int                 rpl;
      int                 failures;
      rsp_type            expected_results [$];

      function new();
         foreach (flag_mem[i]) begin
            flag_mem[i] = FLAGS_VACANT;
            page_mem[i] = '0;
         end
         vpl = int'(VPL_RESET);
         rpl = int'(RPL_RESET);
         failures = 0;
      endfunction

      function void set_limit(logic idx, int value);
         if (idx == CSR_VIRTUAL_PAGE_LIMIT) begin
            vpl = value & ((1 << VPL_W) - 1);
         end else begin
            rpl = value & ((1 << RPL_W) - 1);
         end
      endfunction

      function rsp_type predict_access(req_type r);
         rsp_type            o;
         int                 vp;
         logic [LW-1:0]      off;
         logic [FLAGS_W-1:0] f;
         logic [NRP_W-1:0]   rp;
         logic               vac;
         o = '0;
         o.status = STATUS_OUT_OF_RANGE;
         if (r.mode > MODE_WRITE_MAP) return o;
         if (r.mode == MODE_READ_MAP || r.mode == MODE_WRITE_MAP) begin
            vp = int'(r.page_number);
            off = '0;
         end else begin
            vp = int'(r.virtual_address >> LW);
            off = r.virtual_address[LW-1:0];
         end
         if (vp >= vpl || vp >= VIRTUAL_PAGES_DEF) return o;
         f = flag_mem[vp];
         vac = (f == FLAGS_VACANT);
         rp = vac ? '0 : page_mem[vp];
         o.status = STATUS_OK;
         case (r.mode)
            MODE_FETCH: begin
               if (vac) o.status = STATUS_PAGE_FAULT;
               else flag_mem[vp] = f | FLAG_REF;
            end
            MODE_STORE: begin
               if (vac) o.status = STATUS_PAGE_FAULT;
               else if ((f & FLAG_PROT) != '0) o.status = STATUS_PROT_FAULT;
               else flag_mem[vp] = f | FLAG_REF | FLAG_DIRTY;
            end
            MODE_TRANSLATE: begin
               if (vac) o.status = STATUS_PAGE_FAULT;
            end
            MODE_WRITE_MAP: begin
               if (int'(r.new_real_page) >= rpl) begin
                  o.status = STATUS_OUT_OF_RANGE;
                  return o;
               end
               flag_mem[vp] = r.new_flags;
               page_mem[vp] = (r.new_flags == FLAGS_VACANT) ? '0 : r.new_real_page;
            end
            default: ;
         endcase
         if (r.mode <= MODE_TRANSLATE && o.status == STATUS_OK)
            o.real_address = (RADDR_W'(rp) << LW) | RADDR_W'(off);
         o.entry_flags = f;
         o.entry_real_page = rp;
         o.is_vacant = vac;
         return o;
      endfunction

      function void take_request(req_type r);
         expected_results.push_back(predict_access(r));
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected: %h", got);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("real_address", want.real_address, got.real_address);
         compare_field("entry_flags", want.entry_flags, got.entry_flags);
         compare_field("entry_real_page", want.entry_real_page, got.entry_real_page);
         compare_field("is_vacant", want.is_vacant, got.is_vacant);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_we;
   logic               csr_index;
   logic [CSR_W-1:0]   csr_data;
   logic               quiet;
   int                 ready_hold;
   page_map_shadow     shadow = new();

   page_map_translate_and_mark dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.take_request(req_data);
         if (rsp_valid && rsp_ready) shadow.check_result(rsp_data);
      end
   end

   always @(negedge clock) begin
      if (quiet) begin
         ready_hold = 0;
         rsp_ready = 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
         if (ready_hold == 0) rsp_ready = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_ready = 1'b0;
         ready_hold = $urandom_range(1, 15);
      end
   end

   function automatic req_type access_item(logic [MODE_W-1:0] m, int va);
      req_type it;
      it = {$urandom(), $urandom()};
      it.mode = m;
      it.virtual_address = VADDR_W'(va);
      return it;
   endfunction

   function automatic req_type map_item(logic [MODE_W-1:0] m, int pg, int fl, int nrp);
      req_type it;
      it = {$urandom(), $urandom()};
      it.mode = m;
      it.page_number = PAGE_W'(pg);
      it.new_flags = FLAGS_W'(fl);
      it.new_real_page = NRP_W'(nrp);
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int      pg;
      int      roll;
      int      top;
      it = {$urandom(), $urandom()};
      roll = $urandom_range(0, 99);
      if (roll < 30) it.mode = MODE_WRITE_MAP;
      else if (roll < 40) it.mode = MODE_READ_MAP;
      else if (roll < 60) it.mode = MODE_FETCH;
      else if (roll < 80) it.mode = MODE_STORE;
      else if (roll < 95) it.mode = MODE_TRANSLATE;
      else it.mode = MODE_WRITE_MAP + MODE_W'($urandom_range(1, 3));
      top = (shadow.vpl < 15) ? shadow.vpl : 15;
      case ($urandom_range(0, 9))
         6: pg = shadow.vpl - $urandom_range(0, 1);
         7: pg = VIRTUAL_PAGES_DEF - $urandom_range(0, 1);
         8: pg = $urandom_range(0, PAGE_MAX);
         default: pg = $urandom_range(0, top);
      endcase
      if (pg > PAGE_MAX) pg = PAGE_MAX;
      if (it.mode == MODE_READ_MAP || it.mode == MODE_WRITE_MAP) begin
         it.page_number = PAGE_W'(pg);
      end else begin
         it.virtual_address = (VADDR_W'(pg) << LW) | VADDR_W'($urandom_range(0, (1 << LW) - 1));
      end
      if ($urandom_range(0, 3) == 0) it.new_flags = FLAGS_VACANT;
      top = (shadow.rpl > NRP_MAX + 1) ? NRP_MAX + 1 : shadow.rpl;
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
         it.new_real_page = NRP_W'($urandom_range(0, top - 1));
      end else if (roll < 17) begin
         pg = shadow.rpl - $urandom_range(0, 1);
         it.new_real_page = NRP_W'((pg > NRP_MAX) ? NRP_MAX : pg);
      end
      return it;
   endfunction

   task automatic send_item(input req_type it);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_data = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (shadow.expected_results.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = CSR_W'(value);
      shadow.set_limit(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      req_type opening [$];
      int      vpl_set [PHASES] = '{131072, 1, 300, 16384, 9000};
      int      rpl_set [PHASES] = '{65536, 1, 40000, 32769, 65535};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b1;
      ready_hold = 0;
      csr_we = 1'b0;
      csr_index = CSR_VIRTUAL_PAGE_LIMIT;
      csr_data = '0;
      quiet = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      opening.push_back(access_item(MODE_FETCH, 0));
      opening.push_back(access_item(MODE_STORE, 0));
      opening.push_back(access_item(MODE_TRANSLATE, 0));
      opening.push_back(map_item(MODE_READ_MAP, 0, 0, 0));
      opening.push_back(map_item(MODE_WRITE_MAP, 0, 0, 4095));
      opening.push_back(map_item(MODE_WRITE_MAP, 0, 0, 4096));
      opening.push_back(map_item(MODE_WRITE_MAP, 1, FLAGS_VACANT, 4096));
      opening.push_back(map_item(MODE_WRITE_MAP, 1, FLAGS_VACANT, 5));
      opening.push_back(map_item(MODE_READ_MAP, 1, 0, 0));
      opening.push_back(access_item(MODE_TRANSLATE, (1 << LW) - 1));
      opening.push_back(access_item(MODE_FETCH, 0));
      opening.push_back(access_item(MODE_STORE, 0));
      opening.push_back(map_item(MODE_READ_MAP, 0, 0, 0));
      opening.push_back(map_item(MODE_WRITE_MAP, 2, FLAG_PROT, 7));
      opening.push_back(access_item(MODE_STORE, 2 << LW));
      opening.push_back(access_item(MODE_FETCH, (2 << LW) + 1));
      opening.push_back(map_item(MODE_WRITE_MAP, VIRTUAL_PAGES_DEF - 1, 7, 0));
      opening.push_back(access_item(MODE_TRANSLATE, (VIRTUAL_PAGES_DEF << LW) - 1));
      opening.push_back(access_item(MODE_FETCH, (1 << VADDR_W) - 1));
      opening.push_back(map_item(MODE_READ_MAP, VIRTUAL_PAGES_DEF, 0, 0));
      opening.push_back(map_item(MODE_READ_MAP, PAGE_MAX, 0, 0));
      for (int m = 1; m <= 3; m++)
         opening.push_back(map_item(MODE_WRITE_MAP + MODE_W'(m), 0, 0, 0));
      opening.push_back(map_item(MODE_WRITE_MAP, 3, 7, NRP_MAX));
      foreach (opening[i]) send_item(opening[i]);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_VIRTUAL_PAGE_LIMIT, vpl_set[p]);
         write_csr(CSR_REAL_PAGE_LIMIT, rpl_set[p]);
         if (p == PHASES - 1) quiet = 1'b1;
         repeat (PHASE_ITEMS) send_item(random_item());
      end

      drain();
      repeat (5) @(posedge clock);
      if (shadow.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pmt_pkg.sv
hdl/pmt_map_mem.sv
hdl/pmt_access.sv
hdl/page_map_translate_and_mark.sv
hdl/pmt_checker.sv
tb/page_map_translate_and_mark_tb.sv
